/* rtl/rf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pkg
// Types, constants, micro-program and saturating arithmetic helpers shared
// by the Rusanov flux core.
// ----------------------------------------------------------------------------
package rf_pkg;

    localparam int WORD_W    = 64;
    localparam int N_IN      = 14;
    localparam int JOB_IDX_W = 4;
    localparam int RF_DEPTH  = 48;
    localparam int RF_AW     = 6;
    localparam int UC_LEN    = 66;
    localparam int UC_W      = 7;
    localparam int OUT_BASE  = 40;
    localparam int N_OUT     = 5;
    localparam int OUT_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [N_IN-1:0][WORD_W-1:0] t_job;
    typedef logic [N_OUT-1:0][WORD_W-1:0] t_flux;

    localparam t_word SMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word SMIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Item kinds
    localparam logic OPER_LEFT  = 1'b0;
    localparam logic OPER_RIGHT = 1'b1;

    // Micro-operations
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_HALF   = 4'd2;
    localparam logic [3:0] OP_ABSSUB = 4'd3;
    localparam logic [3:0] OP_ABSADD = 4'd4;
    localparam logic [3:0] OP_MAX    = 4'd5;
    localparam logic [3:0] OP_HSUB   = 4'd6;
    localparam logic [3:0] OP_ZSEL   = 4'd7;
    localparam logic [3:0] OP_MUL    = 4'd8;
    localparam logic [3:0] OP_DIV    = 4'd9;

    typedef struct packed {
        logic [3:0]       op;
        logic [RF_AW-1:0] a;
        logic [RF_AW-1:0] b;
        logic [RF_AW-1:0] d;
    } t_uop;

    function automatic t_uop f_mk(input logic [3:0] op, input int a, input int b,
                                  input int d);
        t_uop u;
        u.op = op;
        u.a  = RF_AW'(a);
        u.b  = RF_AW'(b);
        u.d  = RF_AW'(d);
        return u;
    endfunction

    // Register file map: 0..6 left rho,e,p,u,v,w,a; 7..13 the same for the
    // right side; 40..44 the five fluxes.
    function automatic t_uop f_uop(input logic [UC_W-1:0] step);
        t_uop u;
        case (step)
            7'd0:  u = f_mk(OP_MUL, 0, 3, 14);
            7'd1:  u = f_mk(OP_MUL, 7, 10, 15);
            7'd2:  u = f_mk(OP_MUL, 3, 3, 16);
            7'd3:  u = f_mk(OP_MUL, 4, 4, 17);
            7'd4:  u = f_mk(OP_MUL, 5, 5, 18);
            7'd5:  u = f_mk(OP_ADD, 16, 17, 16);
            7'd6:  u = f_mk(OP_ADD, 16, 18, 16);
            7'd7:  u = f_mk(OP_HALF, 16, 0, 16);
            7'd8:  u = f_mk(OP_MUL, 10, 10, 19);
            7'd9:  u = f_mk(OP_MUL, 11, 11, 20);
            7'd10: u = f_mk(OP_MUL, 12, 12, 21);
            7'd11: u = f_mk(OP_ADD, 19, 20, 19);
            7'd12: u = f_mk(OP_ADD, 19, 21, 19);
            7'd13: u = f_mk(OP_HALF, 19, 0, 19);
            7'd14: u = f_mk(OP_DIV, 2, 0, 20);
            7'd15: u = f_mk(OP_ADD, 1, 20, 20);
            7'd16: u = f_mk(OP_ADD, 20, 16, 20);
            7'd17: u = f_mk(OP_DIV, 9, 7, 21);
            7'd18: u = f_mk(OP_ADD, 8, 21, 21);
            7'd19: u = f_mk(OP_ADD, 21, 19, 21);
            7'd20: u = f_mk(OP_ADD, 1, 16, 22);
            7'd21: u = f_mk(OP_MUL, 0, 22, 22);
            7'd22: u = f_mk(OP_ADD, 8, 19, 23);
            7'd23: u = f_mk(OP_MUL, 7, 23, 23);
            7'd24: u = f_mk(OP_ABSSUB, 3, 6, 24);
            7'd25: u = f_mk(OP_ABSSUB, 10, 13, 25);
            7'd26: u = f_mk(OP_MAX, 24, 25, 24);
            7'd27: u = f_mk(OP_ABSADD, 3, 6, 25);
            7'd28: u = f_mk(OP_MAX, 24, 25, 24);
            7'd29: u = f_mk(OP_ABSADD, 10, 13, 25);
            7'd30: u = f_mk(OP_MAX, 24, 25, 24);
            7'd31: u = f_mk(OP_ADD, 14, 15, 25);
            7'd32: u = f_mk(OP_SUB, 7, 0, 26);
            7'd33: u = f_mk(OP_MUL, 24, 26, 26);
            7'd34: u = f_mk(OP_HSUB, 25, 26, 40);
            7'd35: u = f_mk(OP_MUL, 14, 3, 25);
            7'd36: u = f_mk(OP_ADD, 25, 2, 25);
            7'd37: u = f_mk(OP_MUL, 15, 10, 26);
            7'd38: u = f_mk(OP_ADD, 26, 9, 26);
            7'd39: u = f_mk(OP_ADD, 25, 26, 25);
            7'd40: u = f_mk(OP_SUB, 15, 14, 26);
            7'd41: u = f_mk(OP_MUL, 24, 26, 26);
            7'd42: u = f_mk(OP_HSUB, 25, 26, 41);
            7'd43: u = f_mk(OP_MUL, 14, 4, 25);
            7'd44: u = f_mk(OP_MUL, 15, 11, 26);
            7'd45: u = f_mk(OP_ADD, 25, 26, 25);
            7'd46: u = f_mk(OP_MUL, 7, 11, 26);
            7'd47: u = f_mk(OP_MUL, 0, 4, 27);
            7'd48: u = f_mk(OP_SUB, 26, 27, 26);
            7'd49: u = f_mk(OP_MUL, 24, 26, 26);
            7'd50: u = f_mk(OP_HSUB, 25, 26, 42);
            7'd51: u = f_mk(OP_MUL, 14, 5, 25);
            7'd52: u = f_mk(OP_MUL, 15, 12, 26);
            7'd53: u = f_mk(OP_ADD, 25, 26, 25);
            7'd54: u = f_mk(OP_MUL, 7, 12, 26);
            7'd55: u = f_mk(OP_MUL, 0, 5, 27);
            7'd56: u = f_mk(OP_SUB, 26, 27, 26);
            7'd57: u = f_mk(OP_MUL, 24, 26, 26);
            7'd58: u = f_mk(OP_HSUB, 25, 26, 25);
            7'd59: u = f_mk(OP_ZSEL, 25, 0, 43);
            7'd60: u = f_mk(OP_MUL, 14, 20, 25);
            7'd61: u = f_mk(OP_MUL, 15, 21, 26);
            7'd62: u = f_mk(OP_ADD, 25, 26, 25);
            7'd63: u = f_mk(OP_SUB, 23, 22, 26);
            7'd64: u = f_mk(OP_MUL, 24, 26, 26);
            7'd65: u = f_mk(OP_HSUB, 25, 26, 44);
            default: u = f_mk(OP_ADD, 0, 0, 0);
        endcase
        return u;
    endfunction

    function automatic logic [WORD_W-1:0] f_mag(input t_word a);
        return a[WORD_W-1] ? (WORD_W)'(-a) : a;
    endfunction

    function automatic t_word f_from_mag(input logic neg, input logic big,
                                         input logic [WORD_W-1:0] m);
        t_word r;
        if (neg) begin
            r = (big || m[WORD_W-1]) ? SMIN : t_word'(-m);
        end else begin
            r = (big || m[WORD_W-1]) ? SMAX : t_word'(m);
        end
        return r;
    endfunction

    function automatic t_word f_sadd(input t_word a, input t_word b);
        t_word r;
        r = a + b;
        if (a[WORD_W-1] == b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1]) begin
            r = a[WORD_W-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic t_word f_ssub(input t_word a, input t_word b);
        t_word r;
        r = a - b;
        if (a[WORD_W-1] != b[WORD_W-1] && r[WORD_W-1] != a[WORD_W-1]) begin
            r = a[WORD_W-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic t_word f_half(input t_word a);
        logic [WORD_W-1:0] m;
        m = f_mag(a) >> 1;
        return a[WORD_W-1] ? t_word'(-m) : t_word'(m);
    endfunction

    function automatic t_word f_sabs(input t_word a);
        return (a == SMIN) ? SMAX : t_word'(f_mag(a));
    endfunction

    function automatic t_word f_alu(input logic [3:0] op, input t_word a, input t_word b,
                                    input logic three_d);
        t_word r;
        case (op)
            OP_ADD:    r = f_sadd(a, b);
            OP_SUB:    r = f_ssub(a, b);
            OP_HALF:   r = f_half(a);
            OP_ABSSUB: r = f_sabs(f_ssub(a, b));
            OP_ABSADD: r = f_sabs(f_sadd(a, b));
            OP_MAX:    r = (a > b) ? a : b;
            OP_HSUB:   r = f_ssub(f_half(a), f_half(b));
            OP_ZSEL:   r = three_d ? a : '0;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/rf_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_mul
// Sign-magnitude 64x64 fixed point multiplier built from four 32x32 partial
// products, one per cycle, with truncation and saturation at the end.
// ----------------------------------------------------------------------------
module rf_mul
    import rf_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_result
);

    logic [WORD_W-1:0]   r_x;
    logic [WORD_W-1:0]   r_y;
    logic                r_neg;
    logic [2*WORD_W-1:0] r_acc;
    logic [WORD_W-1:0]   r_pp;
    logic [1:0]          r_sh;
    logic [2:0]          r_cnt;
    logic                r_busy;

    logic [WORD_W/2-1:0] x_half;
    logic [WORD_W/2-1:0] y_half;
    logic [2*WORD_W-1:0] pp_ext;

    // Count 0..3 selects x0y0, x0y1, x1y0, x1y1.
    assign x_half = r_cnt[1] ? r_x[WORD_W-1:WORD_W/2] : r_x[WORD_W/2-1:0];
    assign y_half = r_cnt[0] ? r_y[WORD_W-1:WORD_W/2] : r_y[WORD_W/2-1:0];

    always_comb begin
        case (r_sh)
            2'd0:    pp_ext = {{WORD_W{1'b0}}, r_pp};
            2'd1:    pp_ext = {{(WORD_W/2){1'b0}}, r_pp, {(WORD_W/2){1'b0}}};
            default: pp_ext = {r_pp, {WORD_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= f_mag(i_a);
            r_y    <= f_mag(i_b);
            r_neg  <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_pp <= WORD_W'(x_half * y_half);
                r_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
            end
            if (r_cnt != 3'd0 && r_cnt != 3'd5) begin
                r_acc <= r_acc + pp_ext;
            end
            if (r_cnt == 3'd5) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done   = r_busy && (r_cnt == 3'd5);
    assign o_result = f_from_mag(r_neg, |r_acc[2*WORD_W-1:FRAC_BITS+WORD_W],
                                 r_acc[FRAC_BITS+WORD_W-1:FRAC_BITS]);

endmodule

/* rtl/rf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_div
// Restoring divider for p/rho: one quotient bit per cycle over the
// 64+FRAC_BITS bits of the scaled numerator, saturating on overflow.
// ----------------------------------------------------------------------------
module rf_div
    import rf_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_result
);

    localparam int NW = WORD_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]     r_num;
    logic [NW-1:0]     r_q;
    logic [WORD_W:0]   r_rem;
    logic [WORD_W-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_dz;
    logic              r_nz;

    logic [WORD_W:0] rem_sh;
    logic            fits;

    assign rem_sh = {r_rem[WORD_W-1:0], r_num[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= {i_num, {FRAC_BITS{1'b0}}};
            r_den  <= i_den;
            r_q    <= '0;
            r_rem  <= '0;
            r_dz   <= (i_den == '0);
            r_nz   <= (i_num != '0);
        end else if (r_busy) begin
            if (r_cnt == CW'(NW)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_num <= r_num << 1;
                r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                r_q   <= {r_q[NW-2:0], fits};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(NW));

    // A zero density gives the largest value unless the pressure is zero too.
    assign o_result = r_dz ? (r_nz ? SMAX : '0)
                           : f_from_mag(1'b0, |r_q[NW-1:WORD_W], r_q[WORD_W-1:0]);

endmodule

/* rtl/rf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_front
// Input side: keeps the left state and queues each right-side item, together
// with a copy of the left state, for the compute engine.
// ----------------------------------------------------------------------------
module rf_front
    import rf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_operation,
    input  logic [WORD_W-2:0]  i_density,
    input  logic [WORD_W-2:0]  i_internal_energy,
    input  logic [WORD_W-2:0]  i_pressure,
    input  t_word              i_vel_x,
    input  t_word              i_vel_y,
    input  t_word              i_vel_z,
    input  logic [WORD_W-2:0]  i_sound_speed,
    input  logic               i_job_pop,
    output logic               o_job_valid,
    output t_job               o_job
);

    logic [6:0][WORD_W-1:0] r_left;
    t_job                   r_q [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;

    logic [6:0][WORD_W-1:0] side;
    t_job                   job;
    logic                   accept;
    logic                   do_push;
    logic                   do_pop;

    always_comb begin
        side[0] = {1'b0, i_density};
        side[1] = {1'b0, i_internal_energy};
        side[2] = {1'b0, i_pressure};
        side[3] = i_vel_x;
        side[4] = i_vel_y;
        side[5] = i_vel_z;
        side[6] = {1'b0, i_sound_speed};
        for (int k = 0; k < 7; k++) begin
            job[k]     = r_left[k];
            job[k + 7] = side[k];
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign accept      = i_push && !o_full;
    assign do_push     = accept && (i_operation == OPER_RIGHT);
    assign do_pop      = i_job_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (accept && i_operation == OPER_LEFT) begin
                r_left <= side;
            end
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= job;
        end
    end

endmodule

/* rtl/rf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_back
// Compute engine: a micro-sequenced datapath over a small register file with
// a shared multiplier and divider, and a two-entry result queue.
// ----------------------------------------------------------------------------
module rf_back
    import rf_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_three_d,
    input  logic  i_job_valid,
    input  t_job  i_job,
    output logic  o_job_pop,
    input  logic  i_pop,
    output logic  o_empty,
    output t_flux o_flux
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]           r_state;
    logic [UC_W-1:0]      r_step;
    logic [JOB_IDX_W-1:0] r_ld;
    t_job                 r_job;
    t_word                r_mem [RF_DEPTH];
    t_word                r_rd_a;
    t_word                r_rd_b;
    t_flux                r_res;
    t_flux                r_fq [2];
    logic                 r_fwp;
    logic                 r_frp;
    logic [1:0]           r_fcnt;

    logic [2:0]           n_state;
    logic [UC_W-1:0]      n_step;
    logic [JOB_IDX_W-1:0] n_ld;

    t_uop                 uop;
    logic                 we;
    logic [RF_AW-1:0]     wa;
    t_word                wd;
    logic                 adv;
    logic                 mul_start;
    logic                 div_start;
    logic                 mul_done;
    logic                 div_done;
    t_word                mul_res;
    t_word                div_res;
    logic                 f_push;
    logic                 f_pop;

    assign uop = f_uop(r_step);

    rf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (r_rd_a),
        .i_b      (r_rd_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    rf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_rd_a),
        .i_den    (r_rd_b),
        .o_done   (div_done),
        .o_result (div_res)
    );

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_ld      = r_ld;
        we        = 1'b0;
        wa        = uop.d;
        wd        = f_alu(uop.op, r_rd_a, r_rd_b, i_three_d);
        adv       = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        o_job_pop = 1'b0;
        f_push    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_ld      = '0;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                we = 1'b1;
                wa = RF_AW'(r_ld);
                wd = r_job[r_ld];
                if (r_ld == JOB_IDX_W'(N_IN - 1)) begin
                    n_step  = '0;
                    n_state = S_READ;
                end else begin
                    n_ld = r_ld + 1'b1;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (uop.op == OP_MUL) begin
                    mul_start = 1'b1;
                    n_state   = S_WAIT;
                end else if (uop.op == OP_DIV) begin
                    div_start = 1'b1;
                    n_state   = S_WAIT;
                end else begin
                    we  = 1'b1;
                    adv = 1'b1;
                end
            end
            S_WAIT: begin
                if (uop.op == OP_MUL && mul_done) begin
                    we  = 1'b1;
                    wd  = mul_res;
                    adv = 1'b1;
                end else if (uop.op == OP_DIV && div_done) begin
                    we  = 1'b1;
                    wd  = div_res;
                    adv = 1'b1;
                end
            end
            S_FIN: begin
                if (r_fcnt != 2'd2) begin
                    f_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (adv) begin
            if (r_step == UC_W'(UC_LEN - 1)) begin
                n_state = S_FIN;
            end else begin
                n_step  = r_step + 1'b1;
                n_state = S_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ld    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ld    <= n_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (we && wa >= RF_AW'(OUT_BASE)) begin
            r_res[OUT_IDX_W'(wa - RF_AW'(OUT_BASE))] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_a <= r_mem[uop.a];
        r_rd_b <= r_mem[uop.b];
    end

    // Result queue: the engine may finish a face while the previous one waits.
    assign f_pop   = i_pop && (r_fcnt != 2'd0);
    assign o_empty = (r_fcnt == 2'd0);
    assign o_flux  = r_fq[r_frp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwp  <= 1'b0;
            r_frp  <= 1'b0;
            r_fcnt <= '0;
        end else begin
            if (f_push) begin
                r_fwp <= ~r_fwp;
            end
            if (f_pop) begin
                r_frp <= ~r_frp;
            end
            r_fcnt <= r_fcnt + {1'b0, f_push} - {1'b0, f_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_push) begin
            r_fq[r_fwp] <= r_res;
        end
    end

endmodule

/* rtl/rusanov_flux_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rusanov_flux_core
// Rusanov (local Lax-Friedrichs) face flux for the 3-D Euler equations in
// saturating signed fixed point.
// ----------------------------------------------------------------------------
// A left-state item is taken and produces no result. A right-state item queues
// a face for the compute engine, which runs a fixed program of 66 steps on one
// shared multiplier (27 products) and one bit-serial divider (two divisions).
// Two faces can wait ahead of the engine and two results behind it.
// Register three_d sits at address 0 and should be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module rusanov_flux_core
    import rf_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_operation,
    input  logic [62:0]              i_density,
    input  logic [62:0]              i_internal_energy,
    input  logic [62:0]              i_pressure,
    input  logic signed [63:0]       i_vel_x,
    input  logic signed [63:0]       i_vel_y,
    input  logic signed [63:0]       i_vel_z,
    input  logic [62:0]              i_sound_speed,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [63:0]       o_mass_flux,
    output logic signed [63:0]       o_momentum_x_flux,
    output logic signed [63:0]       o_momentum_y_flux,
    output logic signed [63:0]       o_momentum_z_flux,
    output logic signed [63:0]       o_energy_flux
);

    localparam logic REG_THREE_D = 1'b0;

    logic  r_three_d;
    logic  job_valid;
    logic  job_pop;
    t_job  job;
    t_flux flux;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THREE_D) ? {31'd0, r_three_d} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_THREE_D) begin
            r_three_d <= pwdata[0];
        end
    end

    rf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_operation       (i_operation),
        .i_density         (i_density),
        .i_internal_energy (i_internal_energy),
        .i_pressure        (i_pressure),
        .i_vel_x           (i_vel_x),
        .i_vel_y           (i_vel_y),
        .i_vel_z           (i_vel_z),
        .i_sound_speed     (i_sound_speed),
        .i_job_pop         (job_pop),
        .o_job_valid       (job_valid),
        .o_job             (job)
    );

    rf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_three_d   (r_three_d),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_flux      (flux)
    );

    assign o_mass_flux       = flux[0];
    assign o_momentum_x_flux = flux[1];
    assign o_momentum_y_flux = flux[2];
    assign o_momentum_z_flux = flux[3];
    assign o_energy_flux     = flux[4];

endmodule

/* rtl/rf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_checker
// Port-level checks for the Rusanov flux core, bound to the top level.
// ----------------------------------------------------------------------------
module rf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [63:0] o_mass_flux,
    input logic signed [63:0] o_momentum_x_flux,
    input logic signed [63:0] o_momentum_y_flux,
    input logic signed [63:0] o_momentum_z_flux,
    input logic signed [63:0] o_energy_flux
);

    // Leaving reset, the result queue must be empty and the input queue not full.
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

    // A write to three_d must be visible on the next read.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2])
        |=> (paddr[2] || prdata[0] == $past(pwdata[0])))
        else $error("three_d read-back mismatch");

    // A waiting result holds until its transfer.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mass_flux)
            && $stable(o_momentum_x_flux) && $stable(o_momentum_y_flux)
            && $stable(o_momentum_z_flux) && $stable(o_energy_flux)))
        else $error("waiting result changed before transfer");

endmodule

bind rusanov_flux_core rf_checker u_rf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_mass_flux       (o_mass_flux),
    .o_momentum_x_flux (o_momentum_x_flux),
    .o_momentum_y_flux (o_momentum_y_flux),
    .o_momentum_z_flux (o_momentum_z_flux),
    .o_energy_flux     (o_energy_flux)
);

/* test/rusanov_flux_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rusanov_flux_core_test
// Self-checking bench for the Rusanov face flux core: left and right states
// are pushed with random pacing, faces are predicted in saturating fixed
// point and every popped flux is compared field by field, in order.
// ----------------------------------------------------------------------------
module rusanov_flux_core_test;
    import rf_pkg::*;

    localparam int FRAC = 32;
    localparam int SETTLE = 700;

    typedef struct packed {
        logic        oper;
        logic [62:0] rho;
        logic [62:0] eint;
        logic [62:0] pres;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] w;
        logic [62:0] snd;
    } t_cell_in;

    typedef struct {
        t_word mass;
        t_word mx;
        t_word my;
        t_word mz;
        t_word en;
    } t_face_flux;

    // Fixed-point helpers for the flux predictor.
    function automatic t_word fx_sat(input logic neg, input logic [127:0] m);
        t_word r;
        if (neg) begin
            r = (m >= 128'h8000_0000_0000_0000) ? SMIN : -t_word'(m[63:0]);
        end else begin
            r = (m > 128'h7FFF_FFFF_FFFF_FFFF) ? SMAX : t_word'(m[63:0]);
        end
        return r;
    endfunction

    function automatic logic [63:0] fx_mag(input t_word a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_word fx_add(input t_word a, input t_word b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMAX;
        if (s < -65'sh0_8000_0000_0000_0000) return SMIN;
        return t_word'(s);
    endfunction

    function automatic t_word fx_sub(input t_word a, input t_word b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMAX;
        if (s < -65'sh0_8000_0000_0000_0000) return SMIN;
        return t_word'(s);
    endfunction

    function automatic t_word fx_half(input t_word a);
        return fx_sat(a[63], 128'(fx_mag(a) >> 1));
    endfunction

    function automatic t_word fx_abs(input t_word a);
        return (a == SMIN) ? SMAX : t_word'(fx_mag(a));
    endfunction

    function automatic t_word fx_mul(input t_word a, input t_word b);
        logic [127:0] p;
        p = (128'(fx_mag(a)) * 128'(fx_mag(b))) >> FRAC;
        return fx_sat(a[63] != b[63], p);
    endfunction

    function automatic t_word fx_div(input t_word n, input t_word d);
        logic [127:0] q;
        if (d == 0) return (n != 0) ? SMAX : t_word'(0);
        q = (128'(n) << FRAC) / 128'(d);
        return fx_sat(1'b0, q);
    endfunction

    function automatic t_word fx_max(input t_word a, input t_word b);
        return (a > b) ? a : b;
    endfunction

    class flux_scoreboard;
        t_word      held[7];
        logic       three_d;
        t_face_flux pending[$];
        int         errors;
        int         faces;

        function void clear();
            foreach (held[i]) held[i] = '0;
            three_d = 1'b0;
            errors  = 0;
            faces   = 0;
        endfunction

        function void note_input(input t_cell_in c);
            t_word rl, el, pl, ul, vl, wl, al, rr, er, pr, ur, vr, wr, ar;
            t_word rul, rur, kel, ker, hl, hr, egl, egr, s, t;
            t_face_flux f;
            if (c.oper == OPER_LEFT) begin
                held = '{t_word'(c.rho), t_word'(c.eint), t_word'(c.pres),
                         t_word'(c.u), t_word'(c.v), t_word'(c.w), t_word'(c.snd)};
                return;
            end
            rl = held[0]; el = held[1]; pl = held[2]; ul = held[3];
            vl = held[4]; wl = held[5]; al = held[6];
            rr = t_word'(c.rho); er = t_word'(c.eint); pr = t_word'(c.pres);
            ur = t_word'(c.u); vr = t_word'(c.v); wr = t_word'(c.w);
            ar = t_word'(c.snd);
            rul = fx_mul(rl, ul);
            rur = fx_mul(rr, ur);
            kel = fx_half(fx_add(fx_add(fx_mul(ul, ul), fx_mul(vl, vl)), fx_mul(wl, wl)));
            ker = fx_half(fx_add(fx_add(fx_mul(ur, ur), fx_mul(vr, vr)), fx_mul(wr, wr)));
            hl = fx_add(fx_add(el, fx_div(pl, rl)), kel);
            hr = fx_add(fx_add(er, fx_div(pr, rr)), ker);
            egl = fx_mul(rl, fx_add(el, kel));
            egr = fx_mul(rr, fx_add(er, ker));
            s = fx_max(fx_abs(fx_sub(ul, al)), fx_abs(fx_sub(ur, ar)));
            s = fx_max(s, fx_abs(fx_add(ul, al)));
            s = fx_max(s, fx_abs(fx_add(ur, ar)));
            f.mass = fx_sub(fx_half(fx_add(rul, rur)), fx_half(fx_mul(s, fx_sub(rr, rl))));
            t = fx_add(fx_add(fx_mul(rul, ul), pl), fx_add(fx_mul(rur, ur), pr));
            f.mx = fx_sub(fx_half(t), fx_half(fx_mul(s, fx_sub(rur, rul))));
            t = fx_add(fx_mul(rul, vl), fx_mul(rur, vr));
            f.my = fx_sub(fx_half(t),
                          fx_half(fx_mul(s, fx_sub(fx_mul(rr, vr), fx_mul(rl, vl)))));
            f.mz = '0;
            if (three_d) begin
                t = fx_add(fx_mul(rul, wl), fx_mul(rur, wr));
                f.mz = fx_sub(fx_half(t),
                              fx_half(fx_mul(s, fx_sub(fx_mul(rr, wr), fx_mul(rl, wl)))));
            end
            t = fx_add(fx_mul(rul, hl), fx_mul(rur, hr));
            f.en = fx_sub(fx_half(t), fx_half(fx_mul(s, fx_sub(egr, egl))));
            pending.push_back(f);
        endfunction

        function void field(input string name, input t_word exp_v, input t_word act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input t_face_flux got);
            t_face_flux e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected flux result: expected none actual %h", $time, got.mass);
                return;
            end
            e = pending.pop_front();
            faces++;
            field("mass_flux", e.mass, got.mass);
            field("momentum_x_flux", e.mx, got.mx);
            field("momentum_y_flux", e.my, got.my);
            field("momentum_z_flux", e.mz, got.mz);
            field("energy_flux", e.en, got.en);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_cell_in    drv_item = '0;
    t_word       o_mass, o_mx, o_my, o_mz, o_en;

    logic        rx_idle_on = 1'b1;
    logic        rx_hold = 1'b0;
    logic        tx_idle_on = 1'b1;
    int          pushed = 0;

    flux_scoreboard board;

    always #10 i_clk = ~i_clk;

    rusanov_flux_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .i_operation(drv_item.oper), .i_density(drv_item.rho),
        .i_internal_energy(drv_item.eint), .i_pressure(drv_item.pres),
        .i_vel_x(drv_item.u), .i_vel_y(drv_item.v), .i_vel_z(drv_item.w),
        .i_sound_speed(drv_item.snd),
        .empty(empty), .pop(pop),
        .o_mass_flux(o_mass), .o_momentum_x_flux(o_mx), .o_momentum_y_flux(o_my),
        .o_momentum_z_flux(o_mz), .o_energy_flux(o_en)
    );

    // Result side: random pops, a switchable long hold-off.
    always @(posedge i_clk) begin
        t_face_flux got;
        if (i_rst_n && pop && !empty) begin
            got = '{o_mass, o_mx, o_my, o_mz, o_en};
            board.check_result(got);
        end
        pop <= !rx_hold && (!rx_idle_on || $urandom_range(99) >= 20);
    end

    task automatic write_three_d(input logic val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.three_d = val;
    endtask

    // push stays high after a transfer so that items can follow back to back;
    // the idle loop or drain() lowers it.
    task automatic push_cell(input t_cell_in c);
        while (tx_idle_on && $urandom_range(99) < 20) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        drv_item <= c;
        do @(posedge i_clk); while (full);
        board.note_input(c);
        pushed++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly moderate physical values with occasional full-range words.
    function automatic logic [63:0] pick(input logic signed_f);
        logic [63:0] r;
        case ($urandom_range(9))
            0: r = rnd64();
            1: r = signed_f ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            2: r = 64'd0;
            default: begin
                r = 64'($urandom_range(32'h00FF_FFFF)) << $urandom_range(32, 16);
                if (signed_f && $urandom_range(1)) r = -r;
            end
        endcase
        return r;
    endfunction

    function automatic t_cell_in rnd_cell(input logic oper);
        t_cell_in c;
        c.oper = oper;
        c.rho  = 63'(pick(1'b0));
        c.eint = 63'(pick(1'b0));
        c.pres = 63'(pick(1'b0));
        c.u    = pick(1'b1);
        c.v    = pick(1'b1);
        c.w    = pick(1'b1);
        c.snd  = 63'(pick(1'b0));
        return c;
    endfunction

    function automatic t_cell_in flat_cell(input logic oper, input logic [63:0] x);
        return '{oper, 63'(x), 63'(x), 63'(x), x, x, x, 63'(x)};
    endfunction

    initial begin
        t_cell_in c;
        board = new();
        board.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flux before any left state, zero density, extremes.
        push_cell(flat_cell(OPER_RIGHT, 64'h0000_0001_0000_0000));
        c = flat_cell(OPER_LEFT, 64'd0);
        c.pres = 63'h1_0000_0000;
        push_cell(c);
        push_cell(flat_cell(OPER_RIGHT, 64'd0));
        push_cell(flat_cell(OPER_LEFT, 64'h7FFF_FFFF_FFFF_FFFF));
        push_cell(flat_cell(OPER_RIGHT, 64'h8000_0000_0000_0000));
        push_cell(flat_cell(OPER_RIGHT, 64'hFFFF_FFFF_FFFF_FFFF));
        drain();
        write_three_d(1'b1);
        push_cell(flat_cell(OPER_LEFT, 64'h8000_0000_0000_0000));
        push_cell(flat_cell(OPER_RIGHT, 64'h7FFF_FFFF_FFFF_FFFF));
        push_cell(flat_cell(OPER_LEFT, 64'h0000_0002_8000_0000));
        push_cell(flat_cell(OPER_RIGHT, 64'h0000_0001_4000_0000));
        push_cell(flat_cell(OPER_RIGHT, 64'hFFFF_FFFF_0000_0000));
        drain();

        // Random phases with three_d toggling; several faces per left state.
        for (int ph = 0; ph < 6; ph++) begin
            write_three_d(ph[0]);
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            if (ph == 3) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (4000) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 220; k++) begin
                push_cell(rnd_cell($urandom_range(99) < 55 ? OPER_RIGHT : OPER_LEFT));
            end
            drain();
        end

        $display("Summary: %0d items pushed, %0d faces checked, both three_d settings.",
                 pushed, board.faces);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
